FILE: rtl/core/casg_pkg.sv
package casg_pkg;

   localparam int RAY_DIRS  = 4;
   localparam int RAY_CELLS = 7;
   localparam int LEAPS     = 8;

   // One token that moves down the ray chain
   typedef struct packed {
      logic [63:0]               occupancy;
      logic                      bishop;
      logic [RAY_DIRS-1:0][2:0]  file_pos;
      logic [RAY_DIRS-1:0][2:0]  rank_pos;
      logic [RAY_DIRS-1:0]       alive;
      logic [63:0]               attacks;
   } casg_stage_type;

   // Ray step along file, two's complement
   function automatic logic [3:0] ray_df(input logic bishop, input logic [1:0] dir);
      logic [3:0] delta;
      delta = 4'd0;
      unique case ({bishop, dir})
         3'b000:  delta = 4'b0001;
         3'b001:  delta = 4'b1111;
         3'b010:  delta = 4'b0000;
         3'b011:  delta = 4'b0000;
         3'b100:  delta = 4'b0001;
         3'b101:  delta = 4'b0001;
         3'b110:  delta = 4'b1111;
         3'b111:  delta = 4'b1111;
         default: delta = 4'b0000;
      endcase
      return delta;
   endfunction

   // Ray step along rank
   function automatic logic [3:0] ray_dr(input logic bishop, input logic [1:0] dir);
      logic [3:0] delta;
      delta = 4'd0;
      unique case ({bishop, dir})
         3'b000:  delta = 4'b0000;
         3'b001:  delta = 4'b0000;
         3'b010:  delta = 4'b0001;
         3'b011:  delta = 4'b1111;
         3'b100:  delta = 4'b0001;
         3'b101:  delta = 4'b1111;
         3'b110:  delta = 4'b0001;
         3'b111:  delta = 4'b1111;
         default: delta = 4'b0000;
      endcase
      return delta;
   endfunction

   // Knight jump or king step along file
   function automatic logic [3:0] leap_df(input logic king, input logic [2:0] idx);
      logic [3:0] delta;
      delta = 4'd0;
      unique case ({king, idx})
         4'b0000: delta = 4'b0010;
         4'b0001: delta = 4'b0010;
         4'b0010: delta = 4'b1110;
         4'b0011: delta = 4'b1110;
         4'b0100: delta = 4'b0001;
         4'b0101: delta = 4'b0001;
         4'b0110: delta = 4'b1111;
         4'b0111: delta = 4'b1111;
         4'b1000: delta = 4'b0001;
         4'b1001: delta = 4'b1111;
         4'b1010: delta = 4'b0000;
         4'b1011: delta = 4'b0000;
         4'b1100: delta = 4'b0001;
         4'b1101: delta = 4'b0001;
         4'b1110: delta = 4'b1111;
         4'b1111: delta = 4'b1111;
         default: delta = 4'b0000;
      endcase
      return delta;
   endfunction

   // Knight jump or king step along rank
   function automatic logic [3:0] leap_dr(input logic king, input logic [2:0] idx);
      logic [3:0] delta;
      delta = 4'd0;
      unique case ({king, idx})
         4'b0000: delta = 4'b0001;
         4'b0001: delta = 4'b1111;
         4'b0010: delta = 4'b0001;
         4'b0011: delta = 4'b1111;
         4'b0100: delta = 4'b0010;
         4'b0101: delta = 4'b1110;
         4'b0110: delta = 4'b0010;
         4'b0111: delta = 4'b1110;
         4'b1000: delta = 4'b0000;
         4'b1001: delta = 4'b0000;
         4'b1010: delta = 4'b0001;
         4'b1011: delta = 4'b1111;
         4'b1100: delta = 4'b0001;
         4'b1101: delta = 4'b1111;
         4'b1110: delta = 4'b0001;
         4'b1111: delta = 4'b1111;
         default: delta = 4'b0000;
      endcase
      return delta;
   endfunction

endpackage

FILE: rtl/core/casg_if.sv
interface casg_req_if;
   logic        valid;
   logic        ready;
   logic [5:0]  square;
   logic [63:0] occupancy;
   logic [1:0]  mode;

   modport source (output valid, output square, output occupancy, output mode, input ready);
   modport sink   (input valid, input square, input occupancy, input mode, output ready);
endinterface

interface casg_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] attacks;

   modport source (output valid, output attacks, input ready);
   modport sink   (input valid, input attacks, output ready);
endinterface

FILE: rtl/core/casg_entry_cell.sv
module casg_entry_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    in_valid,
   input  logic [5:0]              square,
   input  logic [63:0]             occupancy,
   input  logic [1:0]              mode,
   output logic                    out_valid,
   output casg_pkg::casg_stage_type stage_out
);

   logic                     valid_ff;
   casg_pkg::casg_stage_type stage_ff;
   casg_pkg::casg_stage_type stage_in;

   always_comb begin
      logic [3:0] nf;
      logic [3:0] nr;
      nf       = 4'd0;
      nr       = 4'd0;
      stage_in = '0;
      stage_in.occupancy = occupancy;
      stage_in.bishop    = mode[0];
      for (int d = 0; d < casg_pkg::RAY_DIRS; d++) begin
         stage_in.file_pos[d] = square[2:0];
         stage_in.rank_pos[d] = square[5:3];
         stage_in.alive[d]    = ~mode[1];
      end
      // leapers finish here; rays are left to the chain
      if (mode[1]) begin
         for (int k = 0; k < casg_pkg::LEAPS; k++) begin
            nf = {1'b0, square[2:0]} + casg_pkg::leap_df(mode[0], 3'(k));
            nr = {1'b0, square[5:3]} + casg_pkg::leap_dr(mode[0], 3'(k));
            if (!nf[3] && !nr[3]) begin
               stage_in.attacks[{nr[2:0], nf[2:0]}] = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign stage_out = stage_ff;

endmodule

FILE: rtl/core/casg_ray_cell.sv
module casg_ray_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    in_valid,
   input  casg_pkg::casg_stage_type stage_in,
   output logic                    out_valid,
   output casg_pkg::casg_stage_type stage_out
);

   logic                     valid_ff;
   casg_pkg::casg_stage_type stage_ff;
   casg_pkg::casg_stage_type step_in;

   // Advance every live ray front by one square
   always_comb begin
      logic [3:0] nf;
      logic [3:0] nr;
      logic [5:0] idx;
      nf      = 4'd0;
      nr      = 4'd0;
      idx     = 6'd0;
      step_in = stage_in;
      for (int d = 0; d < casg_pkg::RAY_DIRS; d++) begin
         if (stage_in.alive[d]) begin
            nf = {1'b0, stage_in.file_pos[d]} + casg_pkg::ray_df(stage_in.bishop, 2'(d));
            nr = {1'b0, stage_in.rank_pos[d]} + casg_pkg::ray_dr(stage_in.bishop, 2'(d));
            if (nf[3] || nr[3]) begin
               step_in.alive[d] = 1'b0;
            end else begin
               idx = {nr[2:0], nf[2:0]};
               step_in.file_pos[d]  = nf[2:0];
               step_in.rank_pos[d]  = nr[2:0];
               step_in.attacks[idx] = 1'b1;
               // blocker is included, then the ray stops
               if (stage_in.occupancy[idx]) begin
                  step_in.alive[d] = 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff <= step_in;
      end
   end

   assign out_valid = valid_ff;
   assign stage_out = stage_ff;

endmodule

FILE: rtl/core/chess_attack_set_generator_unit.sv
// Each item passes the entry cell and then seven ray cells, one register each, before
// its result is valid on rsp.
// Throughput: one item per cycle; each ray cell moves all four ray fronts one square.
// The chain stalls as a whole only while the result register holds an untaken item.
// Reset (synchronous, active high) clears the valid bits of all cells; no clearing pass.
module chess_attack_set_generator_unit (
   input  logic       clock,
   input  logic       reset,
   casg_req_if.sink   req,
   casg_rsp_if.source rsp
);

   logic                     advance;
   logic                     valid_chain [casg_pkg::RAY_CELLS+1];
   casg_pkg::casg_stage_type stage_chain [casg_pkg::RAY_CELLS+1];

   // hold the whole chain while the result waits
   assign advance   = ~valid_chain[casg_pkg::RAY_CELLS] | rsp.ready;
   assign req.ready = advance;

   casg_entry_cell u_entry (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req.valid),
      .square    (req.square),
      .occupancy (req.occupancy),
      .mode      (req.mode),
      .out_valid (valid_chain[0]),
      .stage_out (stage_chain[0])
   );

   for (genvar i = 0; i < casg_pkg::RAY_CELLS; i++) begin : g_ray
      casg_ray_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (valid_chain[i]),
         .stage_in  (stage_chain[i]),
         .out_valid (valid_chain[i+1]),
         .stage_out (stage_chain[i+1])
      );
   end

   assign rsp.valid   = valid_chain[casg_pkg::RAY_CELLS];
   assign rsp.attacks = stage_chain[casg_pkg::RAY_CELLS].attacks;

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.attacks))
      else $error("stalled result changed");

   a_attack_count: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> $countones(rsp.attacks) <= 14)
      else $error("too many attacked squares");

   a_attack_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.attacks != 64'd0)
      else $error("empty attack set");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> valid_chain[0])
      else $error("accepted item missing from entry cell");

endmodule
